// File: hdl/affine_uv_frame_lsq_fit_unit_assert.svh
// assertion macros used by the checker file
`ifndef AFFINE_UV_FRAME_LSQ_FIT_UNIT_ASSERT_SVH
`define AFFINE_UV_FRAME_LSQ_FIT_UNIT_ASSERT_SVH

// clocked check, switched off while reset is high
`define AUFL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds through reset
`define AUFL_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/aufl_pkg.sv
// ----------------------------------------------------------------------------
// aufl_pkg
// Types, constants and operation tables of the affine uv frame fit unit.
// ----------------------------------------------------------------------------
package aufl_pkg;

   localparam int SAMP_W   = 16;
   localparam int PROD_W   = 32;
   localparam int SUM_W    = 48;
   localparam int COF_W    = 100;
   localparam int BIG_W    = 164;
   localparam int RES_W    = 32;
   localparam int THR_W    = 16;
   localparam int QUO_W    = 33;
   localparam int N_SUMS   = 14;
   localparam int N_COFS   = 6;
   localparam int N_RES    = 9;
   localparam int N_OPS    = 42;
   localparam int OP_FIRST_NUM = 15;
   localparam int MIN_SAMPLES  = 3;

   // sum memory map
   localparam logic [3:0] MEM_SU  = 4'd0;
   localparam logic [3:0] MEM_SV  = 4'd1;
   localparam logic [3:0] MEM_SUU = 4'd2;
   localparam logic [3:0] MEM_SUV = 4'd3;
   localparam logic [3:0] MEM_SVV = 4'd4;
   localparam logic [3:0] MEM_RHS = 4'd5;

   // cofactor register map
   localparam logic [3:0] COF_00 = 4'd0;
   localparam logic [3:0] COF_01 = 4'd1;
   localparam logic [3:0] COF_02 = 4'd2;
   localparam logic [3:0] COF_11 = 4'd3;
   localparam logic [3:0] COF_12 = 4'd4;
   localparam logic [3:0] COF_22 = 4'd5;

   // first axis result element; below it lie the origin elements
   localparam logic [3:0] RES_UAXIS = 4'd3;

   // symmetric cofactor matrix, row-major
   localparam logic [3:0] COF_MAP [N_RES] = '{COF_00, COF_01, COF_02,
                                              COF_01, COF_11, COF_12,
                                              COF_02, COF_12, COF_22};

   typedef enum logic [1:0] {MA_ONE, MA_U, MA_V} mul_a_type;
   typedef enum logic [2:0] {MB_ONE, MB_U, MB_V, MB_X, MB_Y, MB_Z} mul_b_type;

   typedef struct packed {
      mul_a_type a;
      mul_b_type b;
   } acc_op_type;

   typedef enum logic [1:0] {SA_CNT, SA_MEM, SA_COF} a_src_type;
   typedef enum logic {SB_CNT, SB_MEM} b_src_type;
   typedef enum logic [1:0] {DST_NONE, DST_COF, DST_DET, DST_NUM} dest_type;

   typedef struct packed {
      a_src_type  a_src;
      logic [3:0] a_idx;
      b_src_type  b_src;
      logic [3:0] b_idx;
      logic       neg;
      logic       clr;
      dest_type   dest;
      logic [3:0] d_idx;
   } solve_op_type;

   // product feeding each sum entry
   function automatic acc_op_type acc_op(input logic [3:0] idx);
      acc_op_type op;
      case (idx)
         4'd0:    op = '{MA_U, MB_ONE};
         4'd1:    op = '{MA_V, MB_ONE};
         4'd2:    op = '{MA_U, MB_U};
         4'd3:    op = '{MA_U, MB_V};
         4'd4:    op = '{MA_V, MB_V};
         4'd5:    op = '{MA_ONE, MB_X};
         4'd6:    op = '{MA_ONE, MB_Y};
         4'd7:    op = '{MA_ONE, MB_Z};
         4'd8:    op = '{MA_U, MB_X};
         4'd9:    op = '{MA_U, MB_Y};
         4'd10:   op = '{MA_U, MB_Z};
         4'd11:   op = '{MA_V, MB_X};
         4'd12:   op = '{MA_V, MB_Y};
         4'd13:   op = '{MA_V, MB_Z};
         default: op = '{MA_ONE, MB_ONE};
      endcase
      return op;
   endfunction

   function automatic solve_op_type mk_op(input a_src_type as, input logic [3:0] ai,
                                          input b_src_type bs, input logic [3:0] bi,
                                          input logic ng, input logic cl,
                                          input dest_type ds, input logic [3:0] di);
      solve_op_type op;
      op.a_src = as;
      op.a_idx = ai;
      op.b_src = bs;
      op.b_idx = bi;
      op.neg   = ng;
      op.clr   = cl;
      op.dest  = ds;
      op.d_idx = di;
      return op;
   endfunction

   // solve program: cofactors, determinant, then adj(A) * B
   function automatic solve_op_type solve_op(input logic [5:0] idx);
      solve_op_type op;
      op = mk_op(SA_CNT, 4'd0, SB_CNT, 4'd0, 1'b0, 1'b0, DST_NONE, 4'd0);
      case (idx)
         6'd0:  op = mk_op(SA_MEM, MEM_SUU, SB_MEM, MEM_SVV, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd1:  op = mk_op(SA_MEM, MEM_SUV, SB_MEM, MEM_SUV, 1'b1, 1'b0, DST_COF, COF_00);
         6'd2:  op = mk_op(SA_MEM, MEM_SV, SB_MEM, MEM_SUV, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd3:  op = mk_op(SA_MEM, MEM_SU, SB_MEM, MEM_SVV, 1'b1, 1'b0, DST_COF, COF_01);
         6'd4:  op = mk_op(SA_MEM, MEM_SU, SB_MEM, MEM_SUV, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd5:  op = mk_op(SA_MEM, MEM_SV, SB_MEM, MEM_SUU, 1'b1, 1'b0, DST_COF, COF_02);
         6'd6:  op = mk_op(SA_CNT, 4'd0, SB_MEM, MEM_SVV, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd7:  op = mk_op(SA_MEM, MEM_SV, SB_MEM, MEM_SV, 1'b1, 1'b0, DST_COF, COF_11);
         6'd8:  op = mk_op(SA_MEM, MEM_SU, SB_MEM, MEM_SV, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd9:  op = mk_op(SA_CNT, 4'd0, SB_MEM, MEM_SUV, 1'b1, 1'b0, DST_COF, COF_12);
         6'd10: op = mk_op(SA_CNT, 4'd0, SB_MEM, MEM_SUU, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd11: op = mk_op(SA_MEM, MEM_SU, SB_MEM, MEM_SU, 1'b1, 1'b0, DST_COF, COF_22);
         6'd12: op = mk_op(SA_COF, COF_00, SB_CNT, 4'd0, 1'b0, 1'b1, DST_NONE, 4'd0);
         6'd13: op = mk_op(SA_COF, COF_01, SB_MEM, MEM_SU, 1'b0, 1'b0, DST_NONE, 4'd0);
         6'd14: op = mk_op(SA_COF, COF_02, SB_MEM, MEM_SV, 1'b0, 1'b0, DST_DET, 4'd0);
         default: begin
            for (int r = 0; r < 3; r++) begin
               for (int j = 0; j < 3; j++) begin
                  for (int k = 0; k < 3; k++) begin
                     if (idx == 6'(OP_FIRST_NUM + 9 * r + 3 * j + k)) begin
                        op = mk_op(SA_COF, COF_MAP[r * 3 + k], SB_MEM,
                                   4'(int'(MEM_RHS) + 3 * k + j), 1'b0, (k == 0),
                                   (k == 2) ? DST_NUM : DST_NONE, 4'(3 * r + j));
                     end
                  end
               end
            end
         end
      endcase
      return op;
   endfunction

endpackage

// File: hdl/aufl_if.sv
// ----------------------------------------------------------------------------
// aufl_req_if / aufl_rsp_if
// Valid/ready channels carrying samples in and fit results out.
// ----------------------------------------------------------------------------
interface aufl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_u;
   logic signed [15:0] sample_v;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic               last_sample;

   modport source (output valid, sample_u, sample_v, point_x, point_y, point_z,
                   last_sample, input ready);
   modport sink (input valid, sample_u, sample_v, point_x, point_y, point_z,
                 last_sample, output ready);
endinterface

interface aufl_rsp_if;
   logic               valid;
   logic               ready;
   logic               fit_ok;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] uaxis_x;
   logic signed [31:0] uaxis_y;
   logic signed [31:0] uaxis_z;
   logic signed [31:0] vaxis_x;
   logic signed [31:0] vaxis_y;
   logic signed [31:0] vaxis_z;

   modport source (output valid, fit_ok, origin_x, origin_y, origin_z, uaxis_x,
                   uaxis_y, uaxis_z, vaxis_x, vaxis_y, vaxis_z, input ready);
   modport sink (input valid, fit_ok, origin_x, origin_y, origin_z, uaxis_x,
                 uaxis_y, uaxis_z, vaxis_x, vaxis_y, vaxis_z, output ready);
endinterface

// File: hdl/affine_uv_frame_lsq_fit_unit.sv
// ----------------------------------------------------------------------------
// affine_uv_frame_lsq_fit_unit
// Least-squares fit of an affine uv frame over a stream of samples.
// ----------------------------------------------------------------------------
// Samples (u, v, x, y, z, signed Q8.8) arrive on req_chan; each accepted
// transaction is folded into fourteen running sums held in a 14 x 48 bit
// memory, one read-modify-write per cycle through one 16 x 16 multiplier.
// A sample therefore occupies the block through accept, 14 reads and the
// final write-back; req_chan.ready is high only between samples.
// A sample with last_sample set starts the solve: 42 shift-add multiply
// steps (cofactors, determinant, adjugate times sums) and a restoring
// division for each of the nine results. One rsp_chan transaction then
// carries fit_ok and the origin and axes in Q16.16; a failed fit
// reports zeros.
// The result sits in an output register: the next samples are taken while
// it waits, but a following solve holds off until it has been taken.
// csr_wr_en writes the determinant threshold (reset value 1).
// Reset empties the sums (per-entry valid bits) and the output register.
// ----------------------------------------------------------------------------
module affine_uv_frame_lsq_fit_unit #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   aufl_req_if.sink            req_chan,
   aufl_rsp_if.source          rsp_chan
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int BW    = aufl_pkg::BIG_W;
   localparam int SW    = aufl_pkg::SUM_W;
   localparam logic [5:0] LAST_BIT = 6'(aufl_pkg::SUM_W - 1);
   localparam logic [5:0] LAST_QB  = 6'(aufl_pkg::QUO_W - 1);
   localparam logic [5:0] LAST_OP  = 6'(aufl_pkg::N_OPS - 1);
   localparam logic [3:0] LAST_SUM = 4'(aufl_pkg::N_SUMS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC, ST_ACC_LAST, ST_WAIT_OUT, ST_OP_RD, ST_OP_LD, ST_OP_MUL,
      ST_OP_WB, ST_DET_ABS, ST_DET_CMP, ST_DIV_ABS, ST_DIV_PREP, ST_DIV_CHK,
      ST_DIV_LOOP, ST_DIV_END, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] su_ff, sv_ff, px_ff, py_ff, pz_ff;
   logic signed [15:0] su_in, sv_in, px_in, py_in, pz_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [aufl_pkg::THR_W-1:0] thr_ff, thr_in;

   // sum memory
   logic [SW-1:0]      mem [aufl_pkg::N_SUMS];
   logic               mem_we;
   logic [3:0]         mem_wa;
   logic [SW-1:0]      mem_wd;
   logic [3:0]         ra_a, ra_b;
   logic [SW-1:0]      rd_a_ff, rd_b_ff;
   logic               rd_a_ok_ff, rd_b_ok_ff;
   logic [aufl_pkg::N_SUMS-1:0] entry_valid_ff, entry_valid_in;
   logic signed [SW-1:0] opa_val, opb_val;

   // accumulate pipeline
   logic [3:0]         idx_ff, idx_in;
   logic [3:0]         wr_idx_ff, wr_idx_in;
   logic               wr_pend_ff, wr_pend_in;
   logic signed [aufl_pkg::PROD_W-1:0] prod_ff, prod_in, prod_w;
   logic signed [15:0] mul_a_val, mul_b_val;
   aufl_pkg::acc_op_type acc_cur;

   // solve datapath
   logic [5:0]         op_idx_ff, op_idx_in;
   aufl_pkg::solve_op_type cur_op;
   logic signed [BW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic signed [SW-1:0] mplier_ff, mplier_in;
   logic [5:0]         bit_ff, bit_in;
   logic signed [aufl_pkg::COF_W-1:0] cof_ff [aufl_pkg::N_COFS];
   logic signed [aufl_pkg::COF_W-1:0] cof_in [aufl_pkg::N_COFS];
   logic signed [BW-1:0] det_ff, det_in;
   logic [BW-1:0]      det_mag_ff, det_mag_in, d2;
   logic signed [BW-1:0] scaled;
   logic [BW-1:0]      num_mag_ff, num_mag_in, n2_ff, n2_in, rem_ff, rem_in, trial;
   logic               neg_ff, neg_in, ovf_ff, ovf_in;
   logic [aufl_pkg::QUO_W-1:0] q_ff, q_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic               sat;

   // result register
   logic signed [aufl_pkg::RES_W-1:0] res_ff [aufl_pkg::N_RES];
   logic signed [aufl_pkg::RES_W-1:0] res_in [aufl_pkg::N_RES];
   logic               fit_ok_ff, fit_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.fit_ok   = fit_ok_ff;
   assign rsp_chan.origin_x = res_ff[0];
   assign rsp_chan.origin_y = res_ff[1];
   assign rsp_chan.origin_z = res_ff[2];
   assign rsp_chan.uaxis_x  = res_ff[3];
   assign rsp_chan.uaxis_y  = res_ff[4];
   assign rsp_chan.uaxis_z  = res_ff[5];
   assign rsp_chan.vaxis_x  = res_ff[6];
   assign rsp_chan.vaxis_y  = res_ff[7];
   assign rsp_chan.vaxis_z  = res_ff[8];

   assign opa_val = rd_a_ok_ff ? $signed(rd_a_ff) : '0;
   assign opb_val = rd_b_ok_ff ? $signed(rd_b_ff) : '0;

   assign acc_cur = aufl_pkg::acc_op(idx_ff);
   assign cur_op  = aufl_pkg::solve_op(op_idx_ff);

   always_comb begin
      case (acc_cur.a)
         aufl_pkg::MA_U: mul_a_val = su_ff;
         aufl_pkg::MA_V: mul_a_val = sv_ff;
         default:        mul_a_val = 16'sd1;
      endcase
      case (acc_cur.b)
         aufl_pkg::MB_U: mul_b_val = su_ff;
         aufl_pkg::MB_V: mul_b_val = sv_ff;
         aufl_pkg::MB_X: mul_b_val = px_ff;
         aufl_pkg::MB_Y: mul_b_val = py_ff;
         aufl_pkg::MB_Z: mul_b_val = pz_ff;
         default:        mul_b_val = 16'sd1;
      endcase
   end

   assign prod_w = mul_a_val * mul_b_val;

   // divider operands
   assign d2     = {det_mag_ff[BW-2:0], 1'b0};
   assign scaled = (cur_op.d_idx < aufl_pkg::RES_UAXIS) ? (acc_ff <<< 8) : (acc_ff <<< 16);
   assign trial  = {rem_ff[BW-2:0], n2_ff[BW-1]};
   assign sat    = ovf_ff | q_ff[aufl_pkg::QUO_W-1] | q_ff[aufl_pkg::QUO_W-2];

   always_comb begin
      state_in       = state_ff;
      su_in          = su_ff;
      sv_in          = sv_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      pz_in          = pz_ff;
      last_in        = last_ff;
      count_in       = count_ff;
      thr_in         = csr_wr_en ? csr_wr_data : thr_ff;
      entry_valid_in = entry_valid_ff;
      idx_in         = idx_ff;
      wr_idx_in      = wr_idx_ff;
      wr_pend_in     = wr_pend_ff;
      prod_in        = prod_ff;
      op_idx_in      = op_idx_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      bit_in         = bit_ff;
      cof_in         = cof_ff;
      det_in         = det_ff;
      det_mag_in     = det_mag_ff;
      num_mag_in     = num_mag_ff;
      n2_in          = n2_ff;
      rem_in         = rem_ff;
      neg_in         = neg_ff;
      ovf_in         = ovf_ff;
      q_in           = q_ff;
      dcnt_in        = dcnt_ff;
      res_in         = res_ff;
      fit_ok_in      = fit_ok_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      mem_we         = 1'b0;
      mem_wa         = wr_idx_ff;
      mem_wd         = opa_val + SW'(prod_ff);
      ra_a           = idx_ff;
      ra_b           = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               su_in      = req_chan.sample_u;
               sv_in      = req_chan.sample_v;
               px_in      = req_chan.point_x;
               py_in      = req_chan.point_y;
               pz_in      = req_chan.point_z;
               last_in    = req_chan.last_sample;
               idx_in     = '0;
               wr_pend_in = 1'b0;
               if (count_ff != CNT_W'(MAX_SAMPLES)) begin
                  state_in = ST_ACC;
               end else if (req_chan.last_sample) begin
                  // full: sample dropped, solve over what is held
                  state_in = ST_WAIT_OUT;
               end
            end
         end
         ST_ACC: begin
            // read entry idx while writing back the previous one
            ra_a      = idx_ff;
            prod_in   = prod_w;
            wr_idx_in = idx_ff;
            if (wr_pend_ff) begin
               mem_we                    = 1'b1;
               entry_valid_in[wr_idx_ff] = 1'b1;
            end
            wr_pend_in = 1'b1;
            if (idx_ff == LAST_SUM) begin
               state_in = ST_ACC_LAST;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_ACC_LAST: begin
            mem_we                    = 1'b1;
            entry_valid_in[wr_idx_ff] = 1'b1;
            wr_pend_in                = 1'b0;
            count_in                  = count_ff + CNT_W'(1);
            state_in                  = last_ff ? ST_WAIT_OUT : ST_IDLE;
         end
         ST_WAIT_OUT: begin
            if (!rsp_valid_ff) begin
               op_idx_in = '0;
               state_in  = ST_OP_RD;
            end
         end
         ST_OP_RD: begin
            ra_a     = cur_op.a_idx;
            ra_b     = cur_op.b_idx;
            state_in = ST_OP_LD;
         end
         ST_OP_LD: begin
            case (cur_op.a_src)
               aufl_pkg::SA_MEM: mcand_in = BW'(opa_val);
               aufl_pkg::SA_COF: mcand_in = BW'(cof_ff[cur_op.a_idx[2:0]]);
               default:          mcand_in = $signed(BW'(count_ff));
            endcase
            mplier_in = (cur_op.b_src == aufl_pkg::SB_MEM) ? opb_val
                                                           : $signed(SW'(count_ff));
            if (cur_op.clr) begin
               acc_in = '0;
            end
            bit_in   = '0;
            state_in = ST_OP_MUL;
         end
         ST_OP_MUL: begin
            // shift-add, the sign bit of the multiplier weighs negative
            if (mplier_ff[0]) begin
               if (cur_op.neg ^ (bit_ff == LAST_BIT)) begin
                  acc_in = acc_ff - mcand_ff;
               end else begin
                  acc_in = acc_ff + mcand_ff;
               end
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >>> 1;
            bit_in    = bit_ff + 6'd1;
            if (bit_ff == LAST_BIT) begin
               state_in = ST_OP_WB;
            end
         end
         ST_OP_WB: begin
            case (cur_op.dest)
               aufl_pkg::DST_DET: begin
                  det_in   = acc_ff;
                  state_in = ST_DET_ABS;
               end
               aufl_pkg::DST_NUM: begin
                  state_in = ST_DIV_ABS;
               end
               aufl_pkg::DST_COF: begin
                  cof_in[cur_op.d_idx[2:0]] = acc_ff[aufl_pkg::COF_W-1:0];
                  op_idx_in = op_idx_ff + 6'd1;
                  state_in  = ST_OP_RD;
               end
               default: begin
                  op_idx_in = op_idx_ff + 6'd1;
                  state_in  = ST_OP_RD;
               end
            endcase
         end
         ST_DET_ABS: begin
            det_mag_in = det_ff[BW-1] ? unsigned'(-det_ff) : unsigned'(det_ff);
            state_in   = ST_DET_CMP;
         end
         ST_DET_CMP: begin
            if (count_ff >= CNT_W'(aufl_pkg::MIN_SAMPLES) && det_mag_ff != '0 &&
                det_mag_ff >= BW'(thr_ff)) begin
               fit_ok_in = 1'b1;
               op_idx_in = op_idx_ff + 6'd1;
               state_in  = ST_OP_RD;
            end else begin
               fit_ok_in = 1'b0;
               for (int e = 0; e < aufl_pkg::N_RES; e++) begin
                  res_in[e] = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DIV_ABS: begin
            num_mag_in = scaled[BW-1] ? unsigned'(-scaled) : unsigned'(scaled);
            neg_in     = scaled[BW-1] ^ det_ff[BW-1];
            state_in   = ST_DIV_PREP;
         end
         ST_DIV_PREP: begin
            // round to nearest: (2|n| + |d|) / 2|d|
            n2_in    = {num_mag_ff[BW-2:0], 1'b0} + det_mag_ff;
            state_in = ST_DIV_CHK;
         end
         ST_DIV_CHK: begin
            ovf_in   = (n2_ff >> aufl_pkg::QUO_W) >= d2;
            rem_in   = n2_ff >> aufl_pkg::QUO_W;
            n2_in    = n2_ff << (BW - aufl_pkg::QUO_W);
            q_in     = '0;
            dcnt_in  = '0;
            state_in = ST_DIV_LOOP;
         end
         ST_DIV_LOOP: begin
            if (trial >= d2) begin
               rem_in = trial - d2;
               q_in   = {q_ff[aufl_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in   = {q_ff[aufl_pkg::QUO_W-2:0], 1'b0};
            end
            n2_in   = n2_ff << 1;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == LAST_QB) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            if (neg_ff) begin
               res_in[cur_op.d_idx] = sat ? 32'sh8000_0000 : -$signed(q_ff[31:0]);
            end else begin
               res_in[cur_op.d_idx] = sat ? 32'sh7fff_ffff : $signed(q_ff[31:0]);
            end
            if (op_idx_ff == LAST_OP) begin
               state_in = ST_DONE;
            end else begin
               op_idx_in = op_idx_ff + 6'd1;
               state_in  = ST_OP_RD;
            end
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            entry_valid_in = '0;
            count_in       = '0;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= mem[ra_a];
      rd_b_ff <= mem[ra_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         thr_ff         <= aufl_pkg::THR_W'(1);
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         thr_ff         <= thr_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_a_ok_ff <= entry_valid_ff[ra_a];
      rd_b_ok_ff <= entry_valid_ff[ra_b];
      su_ff      <= su_in;
      sv_ff      <= sv_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pz_ff      <= pz_in;
      last_ff    <= last_in;
      idx_ff     <= idx_in;
      wr_idx_ff  <= wr_idx_in;
      wr_pend_ff <= wr_pend_in;
      prod_ff    <= prod_in;
      op_idx_ff  <= op_idx_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      bit_ff     <= bit_in;
      cof_ff     <= cof_in;
      det_ff     <= det_in;
      det_mag_ff <= det_mag_in;
      num_mag_ff <= num_mag_in;
      n2_ff      <= n2_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      q_ff       <= q_in;
      dcnt_ff    <= dcnt_in;
      res_ff     <= res_in;
      fit_ok_ff  <= fit_ok_in;
   end

endmodule

// File: hdl/aufl_checker.sv
// ----------------------------------------------------------------------------
// aufl_checker
// Port-level checks of the affine uv frame fit unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "affine_uv_frame_lsq_fit_unit_assert.svh"

module aufl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               fit_ok,
   input logic signed [31:0] origin_x,
   input logic signed [31:0] uaxis_y,
   input logic signed [31:0] vaxis_z
);

   // stalled result transaction keeps its payload
   `AUFL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(fit_ok) && $stable(origin_x) && $stable(vaxis_z), "result changed while stalled")

   // a failed fit carries zeros
   `AUFL_ASSERT(a_fail_zero, rsp_valid && !fit_ok |-> origin_x == 0 && uaxis_y == 0 && vaxis_z == 0, "failed fit with nonzero result")

   // the last sample starts the solve, no transaction taken next cycle
   `AUFL_ASSERT(a_last_busy, req_valid && req_ready && req_last |=> !req_ready, "input taken during solve")

   // reset leaves the block empty and ready
   `AUFL_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind affine_uv_frame_lsq_fit_unit aufl_checker u_aufl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_sample),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .fit_ok    (rsp_chan.fit_ok),
   .origin_x  (rsp_chan.origin_x),
   .uaxis_y   (rsp_chan.uaxis_y),
   .vaxis_z   (rsp_chan.vaxis_z)
);
